@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file of the scheduler.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

@@ hw/rtl/dass_pkg.sv @@
// Package of the daily dose alarm scheduler: types, register indexes and
// the constants of the time-of-day splits. No dependencies.
package dass_pkg;

    // Minute of day, 0..1439 when in range.
    typedef logic [10:0] t_mod;

    // Configuration register indexes.
    localparam logic [2:0] REG_SLOT_COUNT = 3'd0;
    localparam logic [2:0] REG_SLOT0      = 3'd1;
    localparam logic [2:0] REG_MIN_VALID  = 3'd7;

    localparam logic [31:0] MIN_VALID_RESET = 32'd1672531200;
    localparam t_mod        MINUTES_PER_DAY = 11'd1440;
    localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
    localparam logic [5:0]  SECS_PER_MIN    = 6'd60;

    // A day is 2^7 * 675 seconds; the odd factor goes through a reciprocal.
    localparam int unsigned DAY_SHIFT  = 7;
    localparam int unsigned DAY_ODD    = 675;
    localparam logic [15:0] RECIP_675  = 16'd49710;   // floor(2^25 / 675)

    // Sixty is 4 * 15; the odd factor goes through a reciprocal.
    localparam int unsigned SUB_DIV        = 15;
    localparam logic [11:0] RECIP_15_WIDE  = 12'd2184; // floor(2^15 / 15)
    localparam logic [5:0]  RECIP_15_SHORT = 6'd34;    // floor(2^9 / 15)

    // Result of the slot search for one minute of day.
    typedef struct packed {
        logic match;
        logic today_found;
        logic any_found;
        t_mod best_today;
        t_mod best_all;
    } t_slot_sel;

endpackage

@@ hw/rtl/dass_tick_if.sv @@
// Input channel of the scheduler: one tick beat per handshake.
// No dependencies.
interface dass_tick_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_seconds;
    logic        boot_settled;
    logic        time_was_set;

    modport source (output valid, now_seconds, boot_settled, time_was_set, input ready);
    modport sink   (input valid, now_seconds, boot_settled, time_was_set, output ready);
endinterface

@@ hw/rtl/dass_result_if.sv @@
// Output channel of the scheduler: one result beat per tick.
// No dependencies.
interface dass_result_if;
    logic        valid;
    logic        ready;
    logic        dispense_trigger;
    logic        time_valid;
    logic        has_next;
    logic [31:0] next_target_seconds;
    logic [4:0]  remaining_hours;
    logic [5:0]  remaining_minutes;
    logic [5:0]  remaining_secs;

    modport source (output valid, dispense_trigger, time_valid, has_next,
                    next_target_seconds, remaining_hours, remaining_minutes,
                    remaining_secs, input ready);
    modport sink   (input valid, dispense_trigger, time_valid, has_next,
                    next_target_seconds, remaining_hours, remaining_minutes,
                    remaining_secs, output ready);
endinterface

@@ hw/rtl/dass_slot_sel.sv @@
// Parallel slot comparators: match against the current minute of day and
// the earliest later slot today and earliest slot overall. Uses dass_pkg.
module dass_slot_sel import dass_pkg::*; #(
    parameter int SLOTS = 6
) (
    input  logic [2:0] i_slot_count,
    input  t_mod       i_slot [SLOTS],
    input  t_mod       i_cur_mod,
    output t_slot_sel  o_sel
);

    logic [SLOTS-1:0] in_use;
    logic [SLOTS-1:0] usable;

    // A slot is in use below the configured count; counts above SLOTS saturate.
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            in_use[i] = (i_slot_count > 3'(i));
            usable[i] = in_use[i] && (i_slot[i] < MINUTES_PER_DAY);
        end
    end

    // Running minimum over the few slots; out-of-day values are skipped.
    always_comb begin
        o_sel = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (in_use[i] && (i_slot[i] == i_cur_mod)) begin
                o_sel.match = 1'b1;
            end
            if (usable[i]) begin
                if (!o_sel.any_found || (i_slot[i] < o_sel.best_all)) begin
                    o_sel.best_all = i_slot[i];
                end
                o_sel.any_found = 1'b1;
                if (i_slot[i] > i_cur_mod) begin
                    if (!o_sel.today_found || (i_slot[i] < o_sel.best_today)) begin
                        o_sel.best_today = i_slot[i];
                    end
                    o_sel.today_found = 1'b1;
                end
            end
        end
    end

endmodule

@@ hw/rtl/daily_dose_alarm_scheduler.sv @@
// Top level of the daily dose alarm scheduler: configuration registers, the
// nine-stage tick pipeline and the stored minute. Uses dass_pkg, the two
// channel interfaces and dass_slot_sel.
//
//   channel     dir   beat                                   handshake
//   i_tick      in    now_seconds, boot_settled, time_was_set valid/ready
//   o_result    out   trigger, valid flag, next time, left    valid/ready
//   i_cfg_*     in    register index and data                 write enable
//
// One tick is accepted per cycle while the first stage can advance; each
// result beat passes through the stage registers in order and is offered
// on o_result, leaving when the output is not stalled. The time of day is
// split by reciprocal multiplies, each followed by a register.
// Every stage holds its beat while the next one is full, so bubbles are
// squeezed out and ticks are still taken while a result waits.
// Reset is synchronous: it empties the pipeline, marks the stored minute
// invalid and loads the register reset values.
module daily_dose_alarm_scheduler import dass_pkg::*; #(
    parameter int SCHEDULE_SLOTS = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [31:0]      i_cfg_data,
    dass_tick_if.sink        i_tick,
    dass_result_if.source    o_result
);

    localparam int NSTAGE = 9;

    typedef struct packed {
        logic [4:0] q;
        logic [3:0] r;
    } t_div15;

    // Finish a division by 15 from a quotient that may be one low.
    function automatic t_div15 div15_fix(input logic [8:0] x, input logic [4:0] q_est);
        logic [8:0] rem;
        t_div15     res;
        rem = x - 9'(q_est) * 9'(SUB_DIV);
        if (rem >= 9'(SUB_DIV)) begin
            res.q = q_est + 5'd1;
            res.r = 4'(rem - 9'(SUB_DIV));
        end else begin
            res.q = q_est;
            res.r = rem[3:0];
        end
        return res;
    endfunction

    // Configuration registers.
    logic [2:0]  r_slot_count;
    t_mod        r_slot [SCHEDULE_SLOTS];
    logic [31:0] r_min_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= '0;
            r_min_valid  <= MIN_VALID_RESET;
            for (int i = 0; i < SCHEDULE_SLOTS; i++) begin
                r_slot[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_SLOT_COUNT) begin
                r_slot_count <= i_cfg_data[2:0];
            end
            if (i_cfg_idx == REG_MIN_VALID) begin
                r_min_valid <= i_cfg_data;
            end
            for (int i = 0; i < SCHEDULE_SLOTS; i++) begin
                if (i_cfg_idx == 3'(REG_SLOT0 + 3'(i))) begin
                    r_slot[i] <= i_cfg_data[10:0];
                end
            end
        end
    end

    // Pipeline occupancy and elastic advance: a stage loads when it is empty
    // or its own beat moves on.
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] adv;
    logic [NSTAGE-1:0] n_vld;

    always_comb begin
        adv[NSTAGE-1] = !r_vld[NSTAGE-1] || o_result.ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
        n_vld = {r_vld[NSTAGE-2:0], i_tick.valid};
    end

    assign i_tick.ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTAGE; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // Stage 0: input register.
    logic [31:0] r0_now;
    logic        r0_settled;
    logic        r0_wset;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_now     <= i_tick.now_seconds;
            r0_settled <= i_tick.boot_settled;
            r0_wset    <= i_tick.time_was_set;
        end
    end

    // Stage 1: validity test and reciprocal product for the day split.
    logic [31:0] r1_now;
    logic        r1_wset;
    logic        r1_valid;
    logic [40:0] r1_prod;
    logic        n1_valid;

    assign n1_valid = (r0_now >= r_min_valid) || ((r0_now == '0) && !r0_settled);

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_now   <= r0_now;
            r1_wset  <= r0_wset;
            r1_valid <= n1_valid;
            r1_prod  <= 41'(r0_now[31:DAY_SHIFT]) * 41'(RECIP_675);
        end
    end

    // Stage 2: correct the day quotient and form the second of day.
    logic [31:0] r2_now;
    logic        r2_wset;
    logic        r2_valid;
    logic [16:0] r2_tod;
    logic [15:0] n2_q;
    logic [25:0] n2_diff;
    logic [10:0] n2_rem;

    always_comb begin
        n2_q    = r1_prod[40:25];
        n2_diff = 26'(r1_now[31:DAY_SHIFT]) - 26'(n2_q) * 26'(DAY_ODD);
        n2_rem  = (n2_diff[10:0] >= 11'(DAY_ODD)) ? n2_diff[10:0] - 11'(DAY_ODD)
                                                  : n2_diff[10:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r2_now   <= r1_now;
            r2_wset  <= r1_wset;
            r2_valid <= r1_valid;
            r2_tod   <= {n2_rem[9:0], r1_now[DAY_SHIFT-1:0]};
        end
    end

    // Stage 3: start of the day and reciprocal product for the minute split.
    logic        r3_wset;
    logic        r3_valid;
    logic [31:0] r3_day_start;
    logic [16:0] r3_tod;
    logic [26:0] r3_prod;

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r3_wset      <= r2_wset;
            r3_valid     <= r2_valid;
            r3_day_start <= r2_now - 32'(r2_tod);
            r3_tod       <= r2_tod;
            r3_prod      <= 27'(r2_tod[16:2]) * 27'(RECIP_15_WIDE);
        end
    end

    // Stage 4: minute of day and second of minute.
    logic        r4_wset;
    logic        r4_valid;
    logic [31:0] r4_day_start;
    t_mod        r4_cur_mod;
    logic [5:0]  r4_sec;
    t_mod        n4_qe;
    logic [14:0] n4_diff;
    t_mod        n4_cur_mod;
    logic [3:0]  n4_rem;

    always_comb begin
        n4_qe   = r3_prod[25:15];
        n4_diff = 15'(r3_tod[16:2]) - 15'(n4_qe) * 15'(SUB_DIV);
        if (n4_diff[4:0] >= 5'(SUB_DIV)) begin
            n4_cur_mod = n4_qe + 11'd1;
            n4_rem     = 4'(n4_diff[4:0] - 5'(SUB_DIV));
        end else begin
            n4_cur_mod = n4_qe;
            n4_rem     = n4_diff[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r4_wset      <= r3_wset;
            r4_valid     <= r3_valid;
            r4_day_start <= r3_day_start;
            r4_cur_mod   <= n4_cur_mod;
            r4_sec       <= {n4_rem, r3_tod[1:0]};
        end
    end

    // Stage 5: slot search and reciprocal product for the minute of hour.
    t_slot_sel   n5_sel;
    logic        r5_wset;
    logic        r5_valid;
    logic [31:0] r5_day_start;
    t_mod        r5_cur_mod;
    logic [5:0]  r5_sec;
    logic [14:0] r5_prod;
    t_slot_sel   r5_sel;

    dass_slot_sel #(
        .SLOTS (SCHEDULE_SLOTS)
    ) u_slot_sel (
        .i_slot_count (r_slot_count),
        .i_slot       (r_slot),
        .i_cur_mod    (r4_cur_mod),
        .o_sel        (n5_sel)
    );

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r5_wset      <= r4_wset;
            r5_valid     <= r4_valid;
            r5_day_start <= r4_day_start;
            r5_cur_mod   <= r4_cur_mod;
            r5_sec       <= r4_sec;
            r5_prod      <= 15'(r4_cur_mod[10:2]) * 15'(RECIP_15_SHORT);
            r5_sel       <= n5_sel;
        end
    end

    // Stage 6: stored-minute check, trigger and next target.
    logic        r_last_valid;
    logic [5:0]  r_last_min;
    t_div15      n6_hm;
    logic [5:0]  n6_cur_min;
    logic        n6_act;
    logic        n6_lv_eff;
    logic        n6_upd;
    logic        n6_take;
    t_mod        n6_best;
    logic [11:0] n6_dm;
    logic [16:0] n6_best_secs;
    logic [31:0] n6_target;

    always_comb begin
        n6_hm      = div15_fix(r5_cur_mod[10:2], r5_prod[13:9]);
        n6_cur_min = {n6_hm.r, r5_cur_mod[1:0]};
        n6_act     = r5_valid && (r_slot_count != '0);
        n6_lv_eff  = r_last_valid && !r5_wset;
        n6_upd     = n6_act && (!n6_lv_eff || (n6_cur_min != r_last_min));
        n6_take    = adv[6] && r_vld[5];
        n6_best    = r5_sel.today_found ? r5_sel.best_today : r5_sel.best_all;
        if (r5_sel.today_found) begin
            n6_dm = 12'(n6_best) - 12'(r5_cur_mod);
        end else begin
            n6_dm = 12'(MINUTES_PER_DAY) + 12'(n6_best) - 12'(r5_cur_mod);
        end
        n6_best_secs = 17'({n6_best, 6'b0}) - 17'({n6_best, 2'b0});
        n6_target    = r5_day_start + 32'(n6_best_secs)
                     + (r5_sel.today_found ? 32'd0 : 32'(SECS_PER_DAY));
    end

    // The stored minute moves at most once per tick; any write clears its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_valid <= 1'b0;
        end else if (i_cfg_we) begin
            r_last_valid <= 1'b0;
        end else if (n6_take) begin
            r_last_valid <= n6_act || n6_lv_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n6_take && n6_upd) begin
            r_last_min <= n6_cur_min;
        end
    end

    logic        r6_trig;
    logic        r6_valid;
    logic        r6_has;
    logic [31:0] r6_target;
    logic [10:0] r6_tm;
    logic [5:0]  r6_secs;

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r6_trig   <= n6_upd && r5_sel.match;
            r6_valid  <= r5_valid;
            r6_has    <= n6_act && r5_sel.any_found;
            r6_target <= n6_target;
            r6_tm     <= 11'(n6_dm - 12'(r5_sec != '0));
            r6_secs   <= (r5_sec == '0) ? 6'd0 : SECS_PER_MIN - r5_sec;
        end
    end

    // Stage 7: reciprocal product for the remaining-hours split.
    logic        r7_trig;
    logic        r7_valid;
    logic        r7_has;
    logic [31:0] r7_target;
    logic [10:0] r7_tm;
    logic [5:0]  r7_secs;
    logic [14:0] r7_prod;

    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r7_trig   <= r6_trig;
            r7_valid  <= r6_valid;
            r7_has    <= r6_has;
            r7_target <= r6_target;
            r7_tm     <= r6_tm;
            r7_secs   <= r6_secs;
            r7_prod   <= 15'(r6_tm[10:2]) * 15'(RECIP_15_SHORT);
        end
    end

    // Stage 8: output register; fields read zero when there is no next time.
    t_div15      n8_hm;
    logic        r8_trig;
    logic        r8_valid;
    logic        r8_has;
    logic [31:0] r8_target;
    logic [4:0]  r8_hours;
    logic [5:0]  r8_mins;
    logic [5:0]  r8_secs;

    assign n8_hm = div15_fix(r7_tm[10:2], r7_prod[13:9]);

    always_ff @(posedge i_clk) begin
        if (adv[8]) begin
            r8_trig   <= r7_trig;
            r8_valid  <= r7_valid;
            r8_has    <= r7_has;
            r8_target <= r7_has ? r7_target : 32'd0;
            r8_hours  <= r7_has ? n8_hm.q : 5'd0;
            r8_mins   <= r7_has ? {n8_hm.r, r7_tm[1:0]} : 6'd0;
            r8_secs   <= r7_has ? r7_secs : 6'd0;
        end
    end

    assign o_result.valid               = r_vld[NSTAGE-1];
    assign o_result.dispense_trigger    = r8_trig;
    assign o_result.time_valid          = r8_valid;
    assign o_result.has_next            = r8_has;
    assign o_result.next_target_seconds = r8_target;
    assign o_result.remaining_hours     = r8_hours;
    assign o_result.remaining_minutes   = r8_mins;
    assign o_result.remaining_secs      = r8_secs;

endmodule

@@ hw/rtl/dass_checker.sv @@
// Port-level checks on the scheduler's result channel, bound to the top.
// Depends on assert_macros.svh and daily_dose_alarm_scheduler.
`include "assert_macros.svh"

module dass_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic        i_dispense_trigger,
    input logic        i_time_valid,
    input logic        i_has_next,
    input logic [31:0] i_next_target_seconds,
    input logic [4:0]  i_remaining_hours,
    input logic [5:0]  i_remaining_minutes,
    input logic [5:0]  i_remaining_secs
);

    logic        flag_beat;
    logic        fields_zero;
    logic        left_in_range;
    logic [51:0] res_beat;

    // Terms of the checks below.
    assign flag_beat   = i_res_valid && (i_dispense_trigger || i_has_next);
    assign fields_zero = (i_next_target_seconds == 32'd0) && (i_remaining_hours == 5'd0)
                      && (i_remaining_minutes == 6'd0) && (i_remaining_secs == 6'd0);
    assign left_in_range = (i_remaining_minutes <= 6'd59) && (i_remaining_secs <= 6'd59)
        && ((i_remaining_hours < 5'd24) || ((i_remaining_hours == 5'd24)
            && (i_remaining_minutes == 6'd0) && (i_remaining_secs == 6'd0)))
        && ((i_remaining_hours != 5'd0) || (i_remaining_minutes != 6'd0)
            || (i_remaining_secs != 6'd0));
    assign res_beat = {i_dispense_trigger, i_time_valid, i_has_next, i_next_target_seconds,
                       i_remaining_hours, i_remaining_minutes, i_remaining_secs};

    // A pulse or a next time is only given for a set clock.
    `ASSERT_IMPLY(a_flags_need_time, i_clk, i_rst_n, flag_beat, i_time_valid)

    // Without a next time every time field reads zero.
    `ASSERT_IMPLY(a_no_next_zero, i_clk, i_rst_n, i_res_valid && !i_has_next, fields_zero)

    // The time left lies between one second and one full day.
    `ASSERT_IMPLY(a_remaining_range, i_clk, i_rst_n, i_res_valid && i_has_next, left_in_range)

    // A stalled result beat holds.
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(res_beat))

endmodule

bind daily_dose_alarm_scheduler dass_checker u_dass_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_res_valid           (o_result.valid),
    .i_res_ready           (o_result.ready),
    .i_dispense_trigger    (o_result.dispense_trigger),
    .i_time_valid          (o_result.time_valid),
    .i_has_next            (o_result.has_next),
    .i_next_target_seconds (o_result.next_target_seconds),
    .i_remaining_hours     (o_result.remaining_hours),
    .i_remaining_minutes   (o_result.remaining_minutes),
    .i_remaining_secs      (o_result.remaining_secs)
);
